// ----- rtl/core/slq_pkg.sv -----
// Shared types and constants for the sorted-list priority queue.
`default_nettype none

package slq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VAL_W         = 32;
    localparam int CNT_FIELD_W   = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_POP_MIN = 2'd1,
        FUNC_POP_MAX = 2'd2,
        FUNC_REMOVE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Per-request update command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic pop_min;
        logic del;
    } cmd_t;

    // Values rippled from one cell to its right-hand neighbor.
    typedef struct packed {
        logic                    lt;
        logic                    match;
        logic signed [VAL_W-1:0] rem;
        logic signed [VAL_W-1:0] last;
        logic signed [VAL_W-1:0] new_last;
    } chain_t;

endpackage

`default_nettype wire

// ----- rtl/core/slq_if.sv -----
// Request and response channel interfaces of the sorted-list priority queue.
`default_nettype none

interface slq_req_if import slq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface slq_rsp_if import slq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic signed [VAL_W-1:0]       removed_value;
    logic [CNT_FIELD_W-1:0]        entry_count;
    logic signed [VAL_W-1:0]       smallest;
    logic signed [VAL_W-1:0]       largest;

    modport source (output valid, output status, output removed_value,
                    output entry_count, output smallest, output largest,
                    input ready);
    modport sink (input valid, input status, input removed_value,
                  input entry_count, input smallest, input largest,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sorted_list_queue_core.sv -----
// Top level of the sorted-list priority queue: a row of cells plus count and response register.
// A request's response is registered when it is accepted. Throughput: one request per cycle
// unless a held response stalls the request channel; every cell compares against the key in
// the same cycle, and the first-match and largest-value chains ripple through the DEPTH cells.
// Reset clears the entry count and the response valid; cell contents stay undefined and
// are never read before being written, so no clearing pass is needed.
`default_nettype none

module sorted_list_queue_core import slq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    slq_req_if.sink   req,
    slq_rsp_if.source rsp
);

    // The count must hold DEPTH itself, so it is $clog2(DEPTH + 1) bits wide.
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 status_reg;
    logic signed [VAL_W-1:0] removed_reg;
    logic [CNT_FIELD_W-1:0]  entry_count_reg;
    logic signed [VAL_W-1:0] smallest_reg;
    logic signed [VAL_W-1:0] largest_reg;

    logic                    accept;
    logic                    full;
    logic                    empty;
    func_t                   func;
    cmd_t                    cmd;
    status_t                 status;
    logic signed [VAL_W-1:0] removed;

    logic signed [VAL_W-1:0] entry      [DEPTH];
    logic signed [VAL_W-1:0] next_entry [DEPTH];
    chain_t                  chain      [DEPTH+1];

    // A new request is taken whenever the response register is free or draining.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign func      = func_t'(req.func);
    assign full      = count_reg == CW'(DEPTH);
    assign empty     = count_reg == '0;

    // The first cell treats the slot to its left as below the key, so a key
    // smaller than every entry lands at the head. All other chains start cleared.
    assign chain[0].lt       = 1'b1;
    assign chain[0].match    = 1'b0;
    assign chain[0].rem      = '0;
    assign chain[0].last     = '0;
    assign chain[0].new_last = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_head
            assign left_val = req.value;
        end
        else
        begin : g_mid_l
            assign left_val = entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_val = entry[i];
        end
        else
        begin : g_mid_r
            assign right_val = entry[i+1];
        end

        slq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .key        (req.value),
            .count      (count_reg),
            .new_count  (count_next),
            .left_val   (left_val),
            .right_val  (right_val),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .entry      (entry[i]),
            .next_entry (next_entry[i])
        );
    end

    // Decode the request. The match chain depends only on the key, the count and the
    // stored entries, so the delete command can safely be gated by it.
    always_comb
    begin
        cmd        = '0;
        status     = ST_DONE;
        removed    = '0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (func)
                FUNC_INSERT:
                begin
                    if (full)
                        status = ST_FULL;
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                FUNC_POP_MIN:
                begin
                    if (empty)
                        status = ST_EMPTY;
                    else
                    begin
                        cmd.pop_min = 1'b1;
                        removed     = entry[0];
                        count_next  = count_reg - CW'(1);
                    end
                end
                FUNC_POP_MAX:
                begin
                    // The tail cell simply drops out of the valid range.
                    if (empty)
                        status = ST_EMPTY;
                    else
                    begin
                        removed    = chain[DEPTH].last;
                        count_next = count_reg - CW'(1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (empty)
                        status = ST_EMPTY;
                    else if (!chain[DEPTH].match)
                        status = ST_NOTFOUND;
                    else
                    begin
                        cmd.del    = 1'b1;
                        removed    = chain[DEPTH].rem;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status = ST_DONE;
                end
            endcase
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload: loaded with each accepted request, held while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status;
            removed_reg     <= removed;
            entry_count_reg <= CNT_FIELD_W'(count_next);
            smallest_reg    <= (count_next != '0) ? next_entry[0] : '0;
            largest_reg     <= chain[DEPTH].new_last;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.entry_count   = entry_count_reg;
    assign rsp.smallest      = smallest_reg;
    assign rsp.largest       = largest_reg;

    // The count can never run past the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // An insert into a store with room always grows it by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_INSERT && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the store");

    // A full status is only reported when the store really is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status == ST_FULL |=> rsp.valid && count_reg == CW'(DEPTH))
        else $error("full status on a store with room");

    // An empty store reports zero for both extremes.
    a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && count_reg == '0 |-> smallest_reg == '0 && largest_reg == '0)
        else $error("empty store reported nonzero extremes");

endmodule

`default_nettype wire

// ----- rtl/core/slq_cell.sv -----
// One storage cell of the sorted chain: holds a single entry and shifts with its neighbors.
`default_nettype none

module slq_cell import slq_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                    clk,
    input  wire cmd_t                    cmd,
    input  wire logic signed [VAL_W-1:0] key,
    input  wire logic [CW-1:0]           count,
    input  wire logic [CW-1:0]           new_count,
    input  wire logic signed [VAL_W-1:0] left_val,
    input  wire logic signed [VAL_W-1:0] right_val,
    input  wire chain_t                  chain_in,
    output chain_t                       chain_out,
    output logic signed [VAL_W-1:0]      entry,
    output logic signed [VAL_W-1:0]      next_entry
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    valid;
    logic                    new_valid;
    logic                    eq;
    logic                    own_lt;
    logic                    matched;

    assign valid     = CW'(IDX) < count;
    assign new_valid = CW'(IDX) < new_count;
    assign eq        = valid && (entry_reg == key);
    assign own_lt    = valid && (entry_reg < key);
    assign matched   = chain_in.match | eq;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            // The first cell not below the key takes it; the rest shift right.
            if (!own_lt)
                entry_next = chain_in.lt ? key : left_val;
        end
        else if (cmd.pop_min)
            entry_next = right_val;
        else if (cmd.del && matched)
            entry_next = right_val;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign chain_out.lt       = own_lt;
    assign chain_out.match    = matched;
    assign chain_out.rem      = (!chain_in.match && eq) ? entry_reg : chain_in.rem;
    assign chain_out.last     = valid ? entry_reg : chain_in.last;
    assign chain_out.new_last = new_valid ? entry_next : chain_in.new_last;

    assign entry      = entry_reg;
    assign next_entry = entry_next;

endmodule

`default_nettype wire

// ----- test/sorted_list_queue_core_tb.sv -----
// Self-checking testbench for the sorted-list priority queue core.
module sorted_list_queue_core_tb;
    import slq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    // A response is registered in the cycle after its request is accepted, so a few idle
    // cycles at the end are enough to catch any stray response.
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int POOL_SIZE     = 6;

    localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;

    // One request as the driver presents it.
    typedef struct packed {
        func_t                   op;
        logic signed [VAL_W-1:0] key;
    } queue_request_t;

    // One response as the core should return it.
    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [CNT_FIELD_W-1:0]  entry_count;
        logic signed [VAL_W-1:0] smallest;
        logic signed [VAL_W-1:0] largest;
    } queue_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    slq_req_if req_ch ();
    slq_rsp_if rsp_ch ();

    sorted_list_queue_core #(.DEPTH(QUEUE_DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Requests waiting to be driven, and replies waiting to be seen.
    queue_request_t pending_requests[$];
    queue_reply_t   expected_replies[$];

    // Idle rates in percent; the stimulus process changes them per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Shadow of the queue contents, kept in ascending order.
    logic signed [VAL_W-1:0] shadow_entries [QUEUE_DEPTH];
    int unsigned             shadow_fill = 0;

    // Values that random requests keep reusing, so that duplicates pile up
    // and matching removals actually find something.
    logic signed [VAL_W-1:0] key_pool [POOL_SIZE];

    queue_request_t next_request;
    queue_reply_t   want_reply;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] response mismatch: %s", cycle_count, what);
    endtask

    // Applies one accepted request to the shadow contents and queues the
    // response the core owes for it.
    task automatic predict_reply(input func_t op, input logic signed [VAL_W-1:0] key);
        queue_reply_t reply;
        int           pos;
        int           slot;
        reply = '0;
        reply.status = ST_DONE;
        pos = -1;
        if (op == FUNC_INSERT) begin
            if (shadow_fill >= QUEUE_DEPTH) begin
                // A full queue drops the value and leaves everything as it was.
                reply.status = ST_FULL;
            end
            else begin
                // Equal values go after every strictly smaller entry.
                slot = 0;
                while (slot < shadow_fill && shadow_entries[slot] < key)
                    slot++;
                for (int i = shadow_fill; i > slot; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[slot] = key;
                shadow_fill++;
            end
        end
        else if (shadow_fill == 0) begin
            reply.status = ST_EMPTY;
        end
        else begin
            case (op)
                FUNC_POP_MIN: pos = 0;
                FUNC_POP_MAX: pos = shadow_fill - 1;
                default:
                begin
                    // Only the first equal entry goes; duplicates stay.
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (pos < 0 && shadow_entries[i] == key)
                            pos = i;
                    end
                    if (pos < 0)
                        reply.status = ST_NOTFOUND;
                end
            endcase
            if (pos >= 0) begin
                reply.removed_value = shadow_entries[pos];
                for (int i = pos; i + 1 < shadow_fill; i++)
                    shadow_entries[i] = shadow_entries[i+1];
                shadow_fill--;
            end
        end
        reply.entry_count = shadow_fill[CNT_FIELD_W-1:0];
        if (shadow_fill > 0) begin
            reply.smallest = shadow_entries[0];
            reply.largest  = shadow_entries[shadow_fill-1];
        end
        expected_replies.push_back(reply);
    endtask

    task automatic push_request(input func_t op, input logic signed [VAL_W-1:0] key);
        queue_request_t r;
        r.op  = op;
        r.key = key;
        pending_requests.push_back(r);
    endtask

    // Random key: mostly from the shared pool, sometimes an extreme, and
    // otherwise any 32-bit pattern so that every bit toggles.
    function automatic logic signed [VAL_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return key_pool[$urandom_range(POOL_SIZE-1)];
        if (roll < 70) begin
            case ($urandom_range(3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Builds random requests in bursts. Each burst leans toward inserts, toward removals
    // or is balanced, so the queue keeps running into full and empty.
    task automatic queue_random_requests(input int unsigned count);
        int unsigned left;
        int unsigned burst;
        int unsigned insert_pct;
        func_t       op;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(40, 8);
            if (burst > left)
                burst = left;
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            // Refresh the pool: some small clustered values, some wide ones.
            for (int i = 0; i < POOL_SIZE; i++) begin
                if ($urandom_range(1))
                    key_pool[i] = $signed($urandom_range(40)) - 20;
                else
                    key_pool[i] = $urandom;
            end
            repeat (burst) begin
                if ($urandom_range(99) < insert_pct)
                    op = FUNC_INSERT;
                else
                    op = func_t'($urandom_range(3, 1));
                push_request(op, pick_key());
            end
            left -= burst;
        end
    endtask

    // Holds the stimulus until the core has answered everything so far.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_replies.size() != 0);
    endtask

    // Request driver. A request is accepted at a rising edge where valid and
    // ready are both high; the prediction is made at that same edge, from the
    // values that were on the bus just before it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.func  <= FUNC_INSERT;
            req_ch.value <= '0;
        end
        else begin
            if (req_ch.valid && req_ch.ready)
                predict_reply(func_t'(req_ch.func), req_ch.value);
            // The bus may only change once the current request is gone.
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.func  <= next_request.op;
                    req_ch.value <= next_request.key;
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor. Each accepted response is checked field by field
    // against the oldest reply still owed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end
                else begin
                    want_reply = expected_replies.pop_front();
                    if (rsp_ch.status !== want_reply.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            rsp_ch.status, want_reply.status));
                    if (rsp_ch.removed_value !== want_reply.removed_value)
                        report_mismatch($sformatf("removed_value got %0d want %0d",
                            rsp_ch.removed_value, want_reply.removed_value));
                    if (rsp_ch.entry_count !== want_reply.entry_count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                            rsp_ch.entry_count, want_reply.entry_count));
                    if (rsp_ch.smallest !== want_reply.smallest)
                        report_mismatch($sformatf("smallest got %0d want %0d",
                            rsp_ch.smallest, want_reply.smallest));
                    if (rsp_ch.largest !== want_reply.largest)
                        report_mismatch($sformatf("largest got %0d want %0d",
                            rsp_ch.largest, want_reply.largest));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Everything the testbench drives is known from time zero.
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_INSERT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First phase: the sender idles now and then, the receiver often.
        send_idle_pct = 23;
        recv_idle_pct = 66;

        // Removals of every kind from an empty queue.
        push_request(FUNC_POP_MIN, 32'sd5);
        push_request(FUNC_POP_MAX, -32'sd5);
        push_request(FUNC_REMOVE, 32'sd7);
        // Both extremes, then the same value twice so that the second ties with the first.
        push_request(FUNC_INSERT, KEY_MAX);
        push_request(FUNC_INSERT, KEY_MIN);
        push_request(FUNC_INSERT, 32'sd0);
        push_request(FUNC_INSERT, 32'sd0);
        // A matching removal that misses, then one that takes one duplicate.
        push_request(FUNC_REMOVE, 32'sd12345);
        push_request(FUNC_REMOVE, 32'sd0);
        push_request(FUNC_POP_MIN, '0);
        push_request(FUNC_POP_MAX, '0);
        // The last entry leaves, so smallest and largest read back as zero.
        push_request(FUNC_REMOVE, 32'sd0);
        // Fill to capacity, then one insert too many.
        for (int i = 0; i < QUEUE_DEPTH; i++)
            push_request(FUNC_INSERT, (i % 2) ? -$signed(i * 1000) : $signed(i * 77));
        push_request(FUNC_INSERT, -32'sd1);
        queue_random_requests(120);
        // The sender stays quiet here until every reply is back.
        wait_for_drain();

        // Second phase: the idle rates swap sides.
        send_idle_pct = 66;
        recv_idle_pct = 23;
        queue_random_requests(150);
        wait_for_drain();

        // Last phase: back-to-back traffic with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(150);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
